@@ rtl/core/stg_pkg.sv @@
// ----------------------------------------------------------------------------
// stg_pkg
// shared types and constants of the sine tone block generator
// ----------------------------------------------------------------------------
package stg_pkg;

   localparam int MAX_BURST   = 64;
   localparam int PHASE_BITS  = 24;
   localparam int TABLE_BITS  = 10;
   localparam int TABLE_SIZE  = 1 << TABLE_BITS;
   localparam int TONE_OFFSET = 2000;

   localparam int COUNT_W  = 7;
   localparam int INDEX_W  = 16;
   localparam int AMP_W    = 11;
   localparam int STEP_W   = 24;
   localparam int SAMPLE_W = 16;
   localparam int SINE_W   = 16;
   localparam int PROD_W   = AMP_W + 1 + SINE_W;

   typedef struct packed {
      logic [COUNT_W-1:0] sample_count;
      logic [INDEX_W-1:0] start_index;
      logic [AMP_W-1:0]   amplitude;
      logic [STEP_W-1:0]  phase_step;
      logic               stereo;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic [INDEX_W-1:0]  sample_index;
      logic                last;
   } rsp_type;

endpackage

@@ rtl/core/stg_sine_rom.sv @@
// ----------------------------------------------------------------------------
// stg_sine_rom
// full-cycle q1.15 sine table with registered read, built at elaboration
// ----------------------------------------------------------------------------
module stg_sine_rom
   import stg_pkg::*;
(
   input  logic                     clock,
   input  logic [TABLE_BITS-1:0]    addr,
   output logic signed [SINE_W-1:0] data_ff
);

   typedef logic signed [SINE_W-1:0] sine_rom_type [TABLE_SIZE];

   // sin(pi/2 * x) coefficients, q30
   localparam logic [63:0] C1 = 64'd1686629713;
   localparam logic [63:0] C3 = 64'd693598668;
   localparam logic [63:0] C5 = 64'd85569306;
   localparam logic [63:0] C7 = 64'd5026995;
   localparam logic [63:0] C9 = 64'd172272;

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  t;
      logic [63:0]  y;
      logic [63:0]  v;
      int unsigned  quarter;
      int unsigned  q;
      int unsigned  r;
      int unsigned  k;
      quarter = 1 << (TABLE_BITS - 2);
      for (k = 0; k < TABLE_SIZE; k++) begin
         q = k >> (TABLE_BITS - 2);
         r = k & (quarter - 1);
         if ((q & 1) != 0) begin
            r = quarter - r;
         end
         x  = 64'(r) << (32 - TABLE_BITS);
         x2 = (x * x) >> 30;
         t  = C9;
         t  = C7 - ((x2 * t) >> 30);
         t  = C5 - ((x2 * t) >> 30);
         t  = C3 - ((x2 * t) >> 30);
         t  = C1 - ((x2 * t) >> 30);
         y  = (x * t) >> 30;
         v  = (y * 64'd32767 + (64'd1 << 29)) >> 30;
         if (v > 64'd32767) begin
            v = 64'd32767;
         end
         rom[k] = ((q & 2) != 0) ? -SINE_W'(v) : SINE_W'(v);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   always_ff @(posedge clock) begin
      data_ff <= SINE_ROM[addr];
   end

endmodule

@@ rtl/core/stg_scale.sv @@
// ----------------------------------------------------------------------------
// stg_scale
// amplitude multiply with registered product, floor shift, offset and stereo bit add
// ----------------------------------------------------------------------------
module stg_scale
   import stg_pkg::*;
(
   input  logic                     clock,
   input  logic [AMP_W-1:0]         amplitude,
   input  logic signed [SINE_W-1:0] sine,
   input  logic                     stereo,
   output logic [SAMPLE_W-1:0]      sample
);

   logic signed [PROD_W-1:0]        prod_ff;
   logic signed [PROD_W-1:0]        prod_in;
   logic signed [PROD_W-16:0]       scaled;

   assign prod_in = PROD_W'(signed'({1'b0, amplitude})) * PROD_W'(sine);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // arithmetic shift gives the floor of the quotient
   assign scaled = prod_ff[PROD_W-1:15];
   assign sample = SAMPLE_W'(TONE_OFFSET) + SAMPLE_W'(scaled) + SAMPLE_W'(stereo);

endmodule

@@ rtl/core/sine_tone_block_generator.sv @@
// ----------------------------------------------------------------------------
// sine_tone_block_generator
// phase-accumulator sine tone generator, one burst of samples per request
// ----------------------------------------------------------------------------
//   channel   dir   handshake              payload
//   req       in    req_valid / req_stall  req_data  (req_type)
//   rsp       out   rsp_valid / rsp_stall  rsp_data  (rsp_type)
//
// each frame runs table read, multiply and emit; a stereo frame emits two beats
// of the same sample, and emit waits while rsp_stall holds the output register;
// req stays stalled until the last frame of the burst is emitted
// reset clears the sequencer, the output valid and the phase accumulator
// the sequencer waits in emit while the output register is full and stalled
// ----------------------------------------------------------------------------
module sine_tone_block_generator
   import stg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_MUL  = 2'd2;
   localparam logic [1:0] S_EMIT = 2'd3;

   logic [1:0]               state_ff, state_in;
   logic [PHASE_BITS-1:0]    phase_ff, phase_in;
   logic [PHASE_BITS-1:0]    step_ff, step_in;
   logic [AMP_W-1:0]         amp_ff, amp_in;
   logic                     stereo_ff, stereo_in;
   logic                     dup_ff, dup_in;
   logic [COUNT_W-1:0]       frames_left_ff, frames_left_in;
   logic [INDEX_W-1:0]       slot_ff, slot_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic                     req_accept;
   logic                     out_free;
   logic                     beat_last;
   logic [COUNT_W-1:0]       count_sat;
   logic [COUNT_W-1:0]       frames;
   logic signed [SINE_W-1:0] sine;
   logic [SAMPLE_W-1:0]      sample;

   stg_sine_rom u_rom (
      .clock   (clock),
      .addr    (phase_ff[PHASE_BITS-1 -: TABLE_BITS]),
      .data_ff (sine)
   );

   stg_scale u_scale (
      .clock     (clock),
      .amplitude (amp_ff),
      .sine      (sine),
      .stereo    (stereo_ff),
      .sample    (sample)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign beat_last  = (frames_left_ff == COUNT_W'(1)) && (!stereo_ff || dup_ff);

   assign count_sat = (32'(req_data.sample_count) > MAX_BURST) ? COUNT_W'(MAX_BURST)
                                                               : req_data.sample_count;
   assign frames    = req_data.stereo ? (count_sat >> 1) : count_sat;

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      step_in        = step_ff;
      amp_in         = amp_ff;
      stereo_in      = stereo_ff;
      dup_in         = dup_ff;
      frames_left_in = frames_left_ff;
      slot_in        = slot_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               step_in        = PHASE_BITS'(req_data.phase_step);
               amp_in         = req_data.amplitude;
               stereo_in      = req_data.stereo;
               dup_in         = 1'b0;
               frames_left_in = frames;
               slot_in        = req_data.start_index;
               if (frames != '0) begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.sample       = sample;
               rsp_data_in.sample_index = slot_ff;
               rsp_data_in.last         = beat_last;
               slot_in                  = slot_ff + INDEX_W'(1);
               if (stereo_ff && !dup_ff) begin
                  dup_in = 1'b1;
               end else begin
                  dup_in         = 1'b0;
                  phase_in       = phase_ff + step_ff;
                  frames_left_in = frames_left_ff - COUNT_W'(1);
                  state_in       = (frames_left_ff == COUNT_W'(1)) ? S_IDLE : S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= '0;
         dup_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         dup_ff       <= dup_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff        <= step_in;
      amp_ff         <= amp_in;
      stereo_ff      <= stereo_in;
      frames_left_ff <= frames_left_in;
      slot_ff        <= slot_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_new_beat_from_emit: assert property (@(posedge clock) disable iff (reset)
      (out_free && rsp_valid_ff && !$past(rsp_valid_ff && rsp_stall)) |->
         $past(state_ff) == S_EMIT)
      else $error("output beat loaded outside emit");

   a_last_ends_burst: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && out_free && beat_last) |=> state_ff == S_IDLE)
      else $error("sequencer kept running after last beat");

   a_frames_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> frames_left_ff != '0)
      else $error("active burst with no frames left");
`endif

endmodule

@@ bench/sine_tone_block_generator_tb.sv @@
// ----------------------------------------------------------------------------
// sine_tone_block_generator_tb
// The bench sends tone burst requests and checks every sample beat. It covers
// mono and stereo bursts, empty and odd counts, counts that saturate,
// amplitudes above the offset and a wide range of phase steps. A predictor
// with its own phase accumulator and its own Q1.15 sine table works out each
// beat. The sender works in bursts with gaps, and once it pauses until every
// result is back. The receiver changes its stall pattern over the run, and
// once it holds off for a long stretch so that the request side backs up.
// ----------------------------------------------------------------------------
module sine_tone_block_generator_tb;
   import stg_pkg::*;

   localparam int RESET_CYCLES = 9;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int SETTLE_WAIT  = 40;
   localparam int RANDOM_ITEMS = 414;
   localparam int DRAIN_POINT  = 200;
   localparam int HOLD_POINT   = 600;
   localparam int HOLD_CYCLES  = 500;

   localparam longint unsigned SIN_C1 = 64'd1686629713;
   localparam longint unsigned SIN_C3 = 64'd693598668;
   localparam longint unsigned SIN_C5 = 64'd85569306;
   localparam longint unsigned SIN_C7 = 64'd5026995;
   localparam longint unsigned SIN_C9 = 64'd172272;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type pending_q[$];
   rsp_type tone_expect_q[$];
   int      sine_q15[TABLE_SIZE];
   logic [PHASE_BITS-1:0] tone_phase;

   int      items_sent;
   int      items_popped;
   int      results_seen;
   int      fail_count;
   int      burst_left;
   int      gap_left;
   int      mode_left;
   int      hold_left;
   int      pattern_tick;
   bit      long_hold_done;
   longint  cycle_count;
   stall_mode_type stall_mode;
   rsp_type want_beat;

   sine_tone_block_generator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // sin(pi/2 * x), x and result in Q30
   function automatic longint unsigned quarter_wave_q30(input longint unsigned x);
      longint unsigned x2;
      longint unsigned t;
      x2 = (x * x) >> 30;
      t  = SIN_C9;
      t  = SIN_C7 - ((x2 * t) >> 30);
      t  = SIN_C5 - ((x2 * t) >> 30);
      t  = SIN_C3 - ((x2 * t) >> 30);
      t  = SIN_C1 - ((x2 * t) >> 30);
      return (x * t) >> 30;
   endfunction

   function automatic void build_sine_table();
      int unsigned quarter;
      int unsigned q;
      int unsigned r;
      longint unsigned y;
      longint unsigned v;
      quarter = 1 << (TABLE_BITS - 2);
      for (int unsigned k = 0; k < TABLE_SIZE; k++) begin
         q = k >> (TABLE_BITS - 2);
         r = k & (quarter - 1);
         if (q[0]) r = quarter - r;
         y = quarter_wave_q30(longint'(r) << (32 - TABLE_BITS));
         v = (y * 64'd32767 + (64'd1 << 29)) >> 30;
         if (v > 64'd32767) v = 64'd32767;
         sine_q15[k] = q[1] ? -int'(v) : int'(v);
      end
   endfunction

   task automatic predict_tone_burst(input req_type r);
      int count;
      int frames;
      int per;
      int total;
      int n;
      int scaled;
      logic [TABLE_BITS-1:0] slot;
      logic [31:0] level_bits;
      rsp_type beat;
      count  = (r.sample_count > MAX_BURST) ? MAX_BURST : int'(r.sample_count);
      frames = r.stereo ? count / 2 : count;
      per    = r.stereo ? 2 : 1;
      total  = frames * per;
      n      = 0;
      for (int f = 0; f < frames; f++) begin
         slot       = tone_phase[PHASE_BITS-1 -: TABLE_BITS];
         scaled     = (int'(r.amplitude) * sine_q15[slot]) >>> 15;
         level_bits = TONE_OFFSET + scaled + (r.stereo ? 1 : 0);
         for (int j = 0; j < per; j++) begin
            beat.sample       = level_bits[SAMPLE_W-1:0];
            beat.sample_index = r.start_index + INDEX_W'(n);
            beat.last         = (n + 1 == total);
            tone_expect_q.push_back(beat);
            n++;
         end
         tone_phase = tone_phase + r.phase_step;
      end
   endtask

   function automatic req_type tone_req(input int count, input int start, input int amp,
                                        input int step, input bit stereo);
      req_type r;
      r.sample_count = COUNT_W'(count);
      r.start_index  = INDEX_W'(start);
      r.amplitude    = AMP_W'(amp);
      r.phase_step   = STEP_W'(step);
      r.stereo       = stereo;
      return r;
   endfunction

   function automatic req_type random_tone_req();
      int count;
      int amp;
      int step;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 3)       count = 0;
      else if (pick < 70) count = $urandom_range(1, 16);
      else if (pick < 90) count = $urandom_range(17, 64);
      else                count = $urandom_range(65, 127);
      amp = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 2000);
      case ($urandom_range(0, 2))
         0: step = $urandom_range(0, 16'hffff);
         1: step = $urandom_range(0, 24'hffffff);
         default: step = 24'hffffff - $urandom_range(0, 16'hffff);
      endcase
      return tone_req(count, $urandom_range(0, 16'hffff), amp, step, $urandom_range(0, 1));
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         tone_phase = '0;
         burst_left = 1;
         gap_left   = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_tone_burst(req_data);
            items_sent++;
         end
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_q.size() == 0 ||
                         (items_popped == DRAIN_POINT && tone_expect_q.size() != 0)) begin
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_data  <= pending_q.pop_front();
               items_popped++;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
               end
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall    <= 1'b0;
         mode_left    = 0;
         hold_left    = 0;
         pattern_tick = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (tone_expect_q.size() == 0) begin
               $error("unexpected beat: sample %0d sample_index %0d last %0b",
                      rsp_data.sample, rsp_data.sample_index, rsp_data.last);
               fail_count++;
            end else begin
               want_beat = tone_expect_q.pop_front();
               if (rsp_data.sample !== want_beat.sample) begin
                  $error("sample: expected %0d, got %0d", want_beat.sample, rsp_data.sample);
                  fail_count++;
               end
               if (rsp_data.sample_index !== want_beat.sample_index) begin
                  $error("sample_index: expected %0d, got %0d",
                         want_beat.sample_index, rsp_data.sample_index);
                  fail_count++;
               end
               if (rsp_data.last !== want_beat.last) begin
                  $error("last: expected %0b, got %0b", want_beat.last, rsp_data.last);
                  fail_count++;
               end
            end
            results_seen++;
         end
         if (!long_hold_done && results_seen >= HOLD_POINT) begin
            hold_left      = HOLD_CYCLES;
            long_hold_done = 1'b1;
         end
         pattern_tick++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = stall_mode_type'($urandom_range(0, 3));
               mode_left  = $urandom_range(32, 256);
            end
            mode_left--;
            case (stall_mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:     rsp_stall <= ((pattern_tick % 5) < 2);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sine_tone_block_generator_tb: errors");
         $finish;
      end
   end

   initial begin
      build_sine_table();

      pending_q.push_back(tone_req(0,   0,      1000, 24'h100000, 0));
      pending_q.push_back(tone_req(1,   10,     2000, 24'h040000, 0));
      pending_q.push_back(tone_req(64,  100,    2000, 24'h040000, 0));
      pending_q.push_back(tone_req(127, 65500,  2047, 24'hffffff, 0));
      pending_q.push_back(tone_req(65,  200,    1500, 24'h123456, 1));
      pending_q.push_back(tone_req(7,   300,    800,  24'h00abcd, 1));
      pending_q.push_back(tone_req(1,   400,    800,  24'h00abcd, 1));
      pending_q.push_back(tone_req(0,   500,    800,  24'h000001, 1));
      pending_q.push_back(tone_req(10,  65535,  0,    24'h200000, 0));
      pending_q.push_back(tone_req(8,   1,      2047, 24'h400000, 1));
      pending_q.push_back(tone_req(16,  2,      2000, 24'h000000, 0));
      pending_q.push_back(tone_req(4,   3,      1,    24'h800000, 0));
      pending_q.push_back(tone_req(2,   4,      1024, 24'h000001, 1));
      pending_q.push_back(tone_req(32,  16'haaaa, 11'h555, 24'h555555, 0));
      pending_q.push_back(tone_req(63,  16'h5555, 11'h2aa, 24'haaaaaa, 1));
      pending_q.push_back(tone_req(12,  16'hfff0, 1999, 24'h0fffff, 0));
      for (int i = 0; i < RANDOM_ITEMS; i++) pending_q.push_back(random_tone_req());

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || req_valid) @(posedge clock);
      while (tone_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);

      $display("covered %0d tone requests (mono, stereo, empty, odd and saturated counts)",
               items_sent);
      $display("checked %0d sample beats over %0d cycles, %0d mismatches",
               results_seen, cycle_count, fail_count);
      if (fail_count == 0) begin
         $display("sine_tone_block_generator_tb: clean");
      end else begin
         $display("sine_tone_block_generator_tb: errors");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/stg_pkg.sv
rtl/core/stg_sine_rom.sv
rtl/core/stg_scale.sv
rtl/core/sine_tone_block_generator.sv
bench/sine_tone_block_generator_tb.sv
